// File: hw/rtl/fbc_pkg.sv
// fbc_pkg: shared constants, types and the F-function table of the feistel cipher
// no dependencies

package fbc_pkg;

  localparam int BLOCK_W        = 32;
  localparam int HALF_W         = 16;
  localparam int MAX_ROUNDS     = 10;
  localparam int ROUND_COUNT_DEF = 10;
  localparam int DIGITS         = 8;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SUBKEYS_LOW  = 2'd0,
    CFG_SUBKEYS_MID  = 2'd1,
    CFG_SUBKEYS_HIGH = 2'd2
  } cfg_index_t;

  typedef logic [HALF_W-1:0] half_t;
  typedef logic [BLOCK_W-1:0] block_t;

  localparam half_t SEL_TABLE [DIGITS][4] = '{
    '{16'habcb, 16'h7386, 16'h6ea3, 16'h4128},
    '{16'h689b, 16'h22c7, 16'h532d, 16'ha42b},
    '{16'h0e52, 16'hf025, 16'h8724, 16'h9ac0},
    '{16'h776a, 16'h629f, 16'h4510, 16'h3188},
    '{16'h1111, 16'hda99, 16'h52bc, 16'hdead},
    '{16'hdeaf, 16'hbeef, 16'h5810, 16'h7219},
    '{16'h733b, 16'h5ac7, 16'h2468, 16'h9753},
    '{16'h8263, 16'h820d, 16'he72f, 16'h410c}
  };

endpackage

// File: hw/rtl/fbc_if.sv
// fbc_if: valid/ready channel interfaces for plaintext, ciphertext and config words
// depends on fbc_pkg

interface fbc_in_if;
  logic                        valid;
  logic                        ready;
  logic [fbc_pkg::BLOCK_W-1:0] plain_block;
  modport source (output valid, output plain_block, input ready);
  modport sink (input valid, input plain_block, output ready);
endinterface

interface fbc_out_if;
  logic                        valid;
  logic                        ready;
  logic [fbc_pkg::BLOCK_W-1:0] cipher_block;
  modport source (output valid, output cipher_block, input ready);
  modport sink (input valid, input cipher_block, output ready);
endinterface

interface fbc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fbc_pkg::CFG_INDEX_W-1:0] reg_index;
  logic [fbc_pkg::CFG_DATA_W-1:0]  wr_data;
  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: hw/rtl/feistel_block_cipher_32bit.sv
// feistel_block_cipher_32bit: pipelined 32-bit feistel cipher, one round per stage
// depends on fbc_pkg, fbc_if, fbc_round
//
// usage
//   in_ch   : plaintext words, valid/ready, accepted when both are high
//   out_ch  : ciphertext words, valid/ready, one per plaintext word, in order
//   cfg_ch  : subkey register writes, always ready; index 0 low group,
//             1 mid group, 2 high group, other indexes ignored
// pipeline: one stage per round, each stage registers its round output;
//   the last stage register drives out_ch directly
// throughput: one word per cycle while out_ch is not stalled; each stage
//   holds its round logic (eight table lookups and a three-level adder tree)
// stall: each stage holds its word while the next one is full and stalled;
//   empty stages keep filling, so in_ch.ready drops only once the whole
//   pipeline is full behind a stalled receiver; nothing is lost or repeated
// reset: rst_n synchronous active low, clears all stage valid bits and the
//   subkeys to zero; write subkeys only while the pipeline is empty

module feistel_block_cipher_32bit #(
  parameter int ROUND_COUNT = fbc_pkg::ROUND_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fbc_in_if.sink    in_ch,
  fbc_out_if.source out_ch,
  fbc_cfg_if.sink   cfg_ch
);
  import fbc_pkg::*;

  logic [63:0] key_low_r;
  logic [63:0] key_mid_r;
  logic [31:0] key_high_r;
  half_t       subkey [MAX_ROUNDS];

  block_t data_r   [ROUND_COUNT];
  block_t round_in [ROUND_COUNT];
  block_t round_out [ROUND_COUNT];
  logic [ROUND_COUNT-1:0] vld_r;
  logic [ROUND_COUNT-1:0] vld_in;
  logic [ROUND_COUNT-1:0] stg_ready;
  logic [ROUND_COUNT-1:0] next_ready;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_mid_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        CFG_SUBKEYS_LOW:  key_low_r  <= cfg_ch.wr_data;
        CFG_SUBKEYS_MID:  key_mid_r  <= cfg_ch.wr_data;
        CFG_SUBKEYS_HIGH: key_high_r <= cfg_ch.wr_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      subkey[i]   = key_low_r[63-16*i -: HALF_W];
      subkey[i+4] = key_mid_r[63-16*i -: HALF_W];
    end
    subkey[8] = key_high_r[31:16];
    subkey[9] = key_high_r[15:0];
  end

  for (genvar s = 0; s < ROUND_COUNT; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign round_in[s] = in_ch.plain_block;
      assign vld_in[s]   = in_ch.valid;
    end else begin : g_rest
      assign round_in[s] = data_r[s-1];
      assign vld_in[s]   = vld_r[s-1];
    end

    if (s == ROUND_COUNT - 1) begin : g_last
      assign next_ready[s] = out_ch.ready;
    end else begin : g_mid
      assign next_ready[s] = stg_ready[s+1];
    end

    assign stg_ready[s] = !vld_r[s] || next_ready[s];

    fbc_round u_round (
      .subkey    (subkey[s]),
      .block_in  (round_in[s]),
      .block_out (round_out[s])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (stg_ready[s]) begin
        vld_r[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk) begin
      if (stg_ready[s] && vld_in[s]) begin
        data_r[s] <= round_out[s];
      end
    end
  end

  assign in_ch.ready         = stg_ready[0];
  assign out_ch.valid        = vld_r[ROUND_COUNT-1];
  assign out_ch.cipher_block = data_r[ROUND_COUNT-1];

endmodule

// File: hw/rtl/fbc_round.sv
// fbc_round: one feistel round, key xor, table-driven F function and half swap
// depends on fbc_pkg

module fbc_round (
  input  logic [fbc_pkg::HALF_W-1:0]  subkey,
  input  logic [fbc_pkg::BLOCK_W-1:0] block_in,
  output logic [fbc_pkg::BLOCK_W-1:0] block_out
);
  import fbc_pkg::*;

  half_t keyed;
  half_t right;
  half_t words [DIGITS];
  half_t sum_a [4];
  half_t sum_b [2];
  half_t f_out;

  assign keyed = block_in[BLOCK_W-1 -: HALF_W] ^ subkey;
  assign right = block_in[HALF_W-1:0];

  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      words[k] = SEL_TABLE[k][keyed[HALF_W-1-2*k -: 2]];
    end
  end

  // balanced adder tree, mod 2^16
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum_a[i] = words[2*i] + words[2*i+1];
    end
    for (int i = 0; i < 2; i++) begin
      sum_b[i] = sum_a[2*i] + sum_a[2*i+1];
    end
    f_out = sum_b[0] + sum_b[1];
  end

  assign block_out = {f_out ^ right, keyed};

endmodule

// File: hw/rtl/fbc_checker.sv
// fbc_checker: port-level assertions for the feistel cipher pipeline
// depends on fbc_pkg; bound to feistel_block_cipher_32bit

module fbc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [fbc_pkg::BLOCK_W-1:0] cipher_block,
  input logic                        cfg_ready
);
  import fbc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cipher_block))
    else $error("stalled output word changed or dropped");

  a_ready_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while receiver ready");

  a_empty_tail_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty last stage");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

endmodule

bind feistel_block_cipher_32bit fbc_checker u_fbc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .cipher_block (out_ch.cipher_block),
  .cfg_ready    (cfg_ch.ready)
);

// File: test/testbench.sv
// testbench for feistel_block_cipher_32bit: drives plaintext and subkey words, predicts each
// ciphertext word in place and checks the output stream with random idling on both channels
// depends on fbc_pkg, fbc_if and the cipher rtl
`timescale 1ns / 1ps

module testbench;
  import fbc_pkg::*;

  localparam int ROUNDS = 10;
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_UNUSED = 2'd3;
  localparam int MAX_GAP = 12;
  localparam int MAX_REPORTS = 10;

  localparam half_t MIX_TABLE [8][4] = '{
    '{16'habcb, 16'h7386, 16'h6ea3, 16'h4128},
    '{16'h689b, 16'h22c7, 16'h532d, 16'ha42b},
    '{16'h0e52, 16'hf025, 16'h8724, 16'h9ac0},
    '{16'h776a, 16'h629f, 16'h4510, 16'h3188},
    '{16'h1111, 16'hda99, 16'h52bc, 16'hdead},
    '{16'hdeaf, 16'hbeef, 16'h5810, 16'h7219},
    '{16'h733b, 16'h5ac7, 16'h2468, 16'h9753},
    '{16'h8263, 16'h820d, 16'he72f, 16'h410c}
  };

  logic clk = 1'b0;
  logic rst_n;

  fbc_in_if  in_ch ();
  fbc_out_if out_ch ();
  fbc_cfg_if cfg_ch ();

  feistel_block_cipher_32bit #(
    .ROUND_COUNT(ROUNDS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [63:0] keys_low;
  logic [63:0] keys_mid;
  logic [31:0] keys_high;

  block_t pending_cipher [$];
  int send_gap_max = 0;
  int recv_gap_max = 0;
  int hold_off_cycles = 0;
  int words_sent = 0;
  int words_checked = 0;
  int key_writes = 0;
  int failures = 0;

  function automatic half_t round_subkey(input int rd);
    if (rd < 4) return keys_low[48 - 16 * rd +: 16];
    if (rd < 8) return keys_mid[48 - 16 * (rd - 4) +: 16];
    if (rd < 10) return keys_high[16 - 16 * (rd - 8) +: 16];
    return '0;
  endfunction

  function automatic block_t encipher(input block_t blk);
    half_t left;
    half_t right;
    half_t keyed;
    half_t mix;
    left = blk[31:16];
    right = blk[15:0];
    for (int rd = 0; rd < ROUNDS; rd++) begin
      keyed = left ^ round_subkey(rd);
      mix = '0;
      for (int k = 0; k < 8; k++) begin
        mix += MIX_TABLE[k][keyed[14 - 2 * k +: 2]];
      end
      left = mix ^ right;
      right = keyed;
    end
    return {left, right};
  endfunction

  function automatic logic [63:0] draw_key();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic block_t draw_block();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      2: return {16'hffff, 16'(($urandom))};
      default: return $urandom;
    endcase
  endfunction

  // valid stays high between back-to-back writes
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    key_writes++;
    case (idx)
      CFG_SUBKEYS_LOW:  keys_low = data;
      CFG_SUBKEYS_MID:  keys_mid = data;
      CFG_SUBKEYS_HIGH: keys_high = data[31:0];
      default: ;
    endcase
  endtask

  task automatic configure_keys(input logic [63:0] lo, input logic [63:0] mid,
                                input logic [63:0] hi);
    write_reg(CFG_SUBKEYS_LOW, lo);
    write_reg(CFG_SUBKEYS_MID, mid);
    write_reg(CFG_SUBKEYS_HIGH, hi);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_block(input block_t blk);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.plain_block <= blk;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_cipher = {pending_cipher, encipher(blk)};
    words_sent++;
  endtask

  task automatic stop_and_drain();
    in_ch.valid <= 1'b0;
    while (pending_cipher.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_keys();
    block_t blocks [6] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_ffff,
                           32'hffff_0000, 32'h8000_0001, 32'ha5a5_5a5a};
    foreach (blocks[i]) send_block(blocks[i]);
    stop_and_drain();
  endtask

  task automatic test_key_extremes();
    configure_keys('1, '1, '1);
    send_block('0);
    send_block('1);
    send_block(32'h1234_5678);
    stop_and_drain();
    configure_keys(64'h5555_aaaa_0f0f_f0f0, 64'haaaa_5555_f0f0_0f0f, 64'h0000_0000_3c3c_c3c3);
    send_block('0);
    send_block('1);
    send_block(32'h0001_8000);
    stop_and_drain();
  endtask

  // unused index is dropped, high group keeps only its low 32 bits
  task automatic test_ignored_writes();
    write_reg(CFG_INDEX_UNUSED, {$urandom, $urandom});
    write_reg(CFG_SUBKEYS_HIGH, {32'hdead_beef, 32'h1357_9bdf});
    write_reg(CFG_INDEX_UNUSED, '1);
    cfg_ch.valid <= 1'b0;
    send_block('0);
    send_block('1);
    send_block(32'hc0de_0042);
    send_block(32'h7fff_8000);
    stop_and_drain();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_SUBKEYS_LOW, draw_key());
      write_reg(CFG_SUBKEYS_MID, draw_key());
      write_reg(CFG_SUBKEYS_HIGH, draw_key());
      if (phase > 0 && $urandom_range(0, 1)) begin
        write_reg(CFG_SUBKEYS_MID, draw_key());
      end
      cfg_ch.valid <= 1'b0;
      case (phase % 4)
        0: begin send_gap_max = 0;       recv_gap_max = 0; end
        1: begin send_gap_max = MAX_GAP; recv_gap_max = MAX_GAP; end
        2: begin send_gap_max = 0;       recv_gap_max = MAX_GAP; end
        default: begin send_gap_max = MAX_GAP; recv_gap_max = 0; end
      endcase
      repeat (160) send_block(draw_block());
      stop_and_drain();
    end
  endtask

  task automatic test_backpressure();
    send_gap_max = 0;
    recv_gap_max = 0;
    hold_off_cycles = 80;
    repeat (40) send_block(draw_block());
    stop_and_drain();
  endtask

  task automatic test_sender_pause();
    send_gap_max = MAX_GAP;
    recv_gap_max = MAX_GAP;
    for (int burst = 0; burst < 12; burst++) begin
      repeat ($urandom_range(1, 8)) send_block(draw_block());
      stop_and_drain();
    end
  endtask

  initial begin : receiver
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      stall = $urandom_range(0, recv_gap_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_cipher
    block_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_checked++;
      if (pending_cipher.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected cipher word %08h", out_ch.cipher_block);
      end else begin
        want = pending_cipher.pop_front();
        if (out_ch.cipher_block !== want) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("cipher_block mismatch: expected %08h actual %08h",
                     want, out_ch.cipher_block);
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    keys_low = '0;
    keys_mid = '0;
    keys_high = '0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.plain_block <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reg_index <= '0;
    cfg_ch.wr_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_keys();
    test_key_extremes();
    test_ignored_writes();
    test_random_traffic();
    test_backpressure();
    test_sender_pause();

    repeat (ROUNDS + 4) @(posedge clk);
    $display("sent %0d plaintext words and checked %0d cipher words over %0d subkey writes,",
             words_sent, words_checked, key_writes);
    $display("with random idling, a long output hold-off and drained bursts");
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", failures);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/fbc_pkg.sv
hw/rtl/fbc_if.sv
hw/rtl/fbc_round.sv
hw/rtl/feistel_block_cipher_32bit.sv
hw/rtl/fbc_checker.sv
test/testbench.sv
